// File: rtl/epbc_pkg.sv
// package for the encoder pd balance controller
// widths, reset values, register indexes and the encoder unwrap function
// no dependencies
package epbc_pkg;

    localparam int COUNT_BITS = 12;
    localparam int POS_W      = 16;
    localparam int GAIN_W     = 24;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int FRAC_BITS  = 12;
    localparam int PROD_W     = GAIN_W + POS_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int DRIVE_MAX  = 127;
    localparam int DRIVE_MIN  = -128;

    localparam logic signed [GAIN_W-1:0] GAIN_NOW_RST  = GAIN_W'(7405378);
    localparam logic signed [GAIN_W-1:0] GAIN_PAST_RST = GAIN_W'(-7374658);
    localparam logic [BYTE_W-1:0]        START_RST     = BYTE_W'(127);
    localparam logic [BYTE_W-1:0]        IDLE_RST      = BYTE_W'(127);
    localparam logic [POS_W-1:0]         REF_RST       = POS_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_NOW   = 2'd0,
        CFG_GAIN_PAST  = 2'd1,
        CFG_START      = 2'd2,
        CFG_IDLE_DRIVE = 2'd3
    } t_cfg_idx;

    localparam logic signed [COUNT_BITS+1:0] CNT_FULL = (COUNT_BITS+2)'(1 << COUNT_BITS);
    localparam logic signed [COUNT_BITS+1:0] CNT_HALF = (COUNT_BITS+2)'(1 << (COUNT_BITS-1));

    // count difference folded into -half..half, extended or cut to position width
    function automatic logic [POS_W-1:0] unwrap_delta(
        input logic [COUNT_BITS-1:0] now_cnt,
        input logic [COUNT_BITS-1:0] prev_cnt
    );
        logic signed [COUNT_BITS+1:0] d;
        d = $signed({2'b00, now_cnt}) - $signed({2'b00, prev_cnt});
        if (d > CNT_HALF) begin
            d = d - CNT_FULL;
        end else if (d < -CNT_HALF) begin
            d = d + CNT_FULL;
        end
        return POS_W'(d);
    endfunction

endpackage

// File: rtl/encoder_pd_balance_controller_top.sv
// encoder pd balance controller, single module
// depends on epbc_pkg
//
// usage:
//   input channel (i_valid / o_ready) carries one tick: two absolute encoder
//   counts and the sampled button byte. output channel (o_valid / i_ready)
//   carries one result per tick: drive code, both accumulated positions and
//   the running flag.
//   config port: i_cfg_we with i_cfg_index / i_cfg_data writes a register at
//   the clock edge; write only while no tick is in flight.
//   throughput: one tick per cycle while the receiver keeps up, set by a
//   three-stage pipeline (unwrap and error, two parallel gain multiplies,
//   sum/divide/saturate). encoder state and reference update at the input
//   transfer; previous error updates there too once running.
//   reset (synchronous, active low) empties the pipeline, clears positions,
//   counts and previous error, sets reference to 1000, not running, and
//   loads the default gains, start pattern and idle drive.
//   when the receiver stalls, each stage holds; empty stages ahead still
//   fill, so up to three ticks are taken before o_ready drops.
module encoder_pd_balance_controller_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [epbc_pkg::COUNT_BITS-1:0]    i_motor_count,
    input  logic [epbc_pkg::COUNT_BITS-1:0]    i_pendulum_count,
    input  logic [epbc_pkg::BYTE_W-1:0]        i_button_byte,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [epbc_pkg::BYTE_W-1:0]        o_drive_code,
    output logic signed [epbc_pkg::POS_W-1:0]  o_motor_position,
    output logic signed [epbc_pkg::POS_W-1:0]  o_pendulum_position,
    output logic                               o_running,
    input  logic                               i_cfg_we,
    input  logic [epbc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [epbc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import epbc_pkg::*;

    localparam logic signed [SUM_W-1:0] DIV_BIAS = SUM_W'((1 << FRAC_BITS) - 1);
    localparam logic signed [SUM_W-1:0] Q_MAX    = SUM_W'(DRIVE_MAX);
    localparam logic signed [SUM_W-1:0] Q_MIN    = SUM_W'(DRIVE_MIN);

    // configuration
    logic signed [GAIN_W-1:0] r_gain_now;
    logic signed [GAIN_W-1:0] r_gain_past;
    logic [BYTE_W-1:0]        r_start_pattern;
    logic [BYTE_W-1:0]        r_idle_drive;

    // controller state
    logic [COUNT_BITS-1:0]    r_motor_prev;
    logic [COUNT_BITS-1:0]    r_pend_prev;
    logic [POS_W-1:0]         r_motor_acc;
    logic [POS_W-1:0]         r_pend_acc;
    logic [POS_W-1:0]         r_reference;
    logic                     r_started;
    logic [POS_W-1:0]         r_prev_err;

    // pipeline valids and flow control
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;
    logic in_xfer;

    // stage 1
    logic signed [POS_W-1:0]  r_s1_err;
    logic signed [POS_W-1:0]  r_s1_ep;
    logic                     r_s1_run;
    logic [POS_W-1:0]         r_s1_mpos;
    logic [POS_W-1:0]         r_s1_ppos;

    // stage 2
    logic signed [PROD_W-1:0] r_p_now;
    logic signed [PROD_W-1:0] r_p_past;
    logic                     r_s2_run;
    logic [POS_W-1:0]         r_s2_mpos;
    logic [POS_W-1:0]         r_s2_ppos;

    // output stage
    logic [BYTE_W-1:0]        r_drive;
    logic [POS_W-1:0]         r_out_mpos;
    logic [POS_W-1:0]         r_out_ppos;
    logic                     r_out_run;

    logic [POS_W-1:0]         n_motor_acc;
    logic [POS_W-1:0]         n_pend_acc;
    logic                     start_hit;
    logic [POS_W-1:0]         n_reference;
    logic                     n_started;
    logic [POS_W-1:0]         n_err;
    logic signed [PROD_W-1:0] n_p_now;
    logic signed [PROD_W-1:0] n_p_past;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  q;
    logic [BYTE_W-1:0]        n_drive;

    // each stage moves when the one after it is empty or moving
    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign in_xfer = i_valid && o_ready;

    // stage 1 logic: unwrap, start detect, error
    always_comb begin
        n_motor_acc = r_motor_acc + unwrap_delta(i_motor_count, r_motor_prev);
        n_pend_acc  = r_pend_acc + unwrap_delta(i_pendulum_count, r_pend_prev);
        start_hit   = (i_button_byte == r_start_pattern);
        n_reference = start_hit ? n_pend_acc : r_reference;
        n_started   = r_started || start_hit;
        n_err       = n_reference - n_pend_acc;
    end

    // stage 2 logic: gain products
    assign n_p_now  = PROD_W'(r_gain_now) * PROD_W'(r_s1_err);
    assign n_p_past = PROD_W'(r_gain_past) * PROD_W'(r_s1_ep);

    // stage 3: divide toward zero, saturate, offset by 128, or idle drive
    always_comb begin
        sum = SUM_W'(r_p_now) + SUM_W'(r_p_past);
        if (sum[SUM_W-1]) begin
            q = (sum + DIV_BIAS) >>> FRAC_BITS;
        end else begin
            q = sum >>> FRAC_BITS;
        end
        priority if (q > Q_MAX) begin
            q = Q_MAX;
        end else if (q < Q_MIN) begin
            q = Q_MIN;
        end else begin
            q = q;
        end
        if (r_s2_run) begin
            n_drive = {~q[BYTE_W-1], q[BYTE_W-2:0]};
        end else begin
            n_drive = r_idle_drive;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_now      <= GAIN_NOW_RST;
            r_gain_past     <= GAIN_PAST_RST;
            r_start_pattern <= START_RST;
            r_idle_drive    <= IDLE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_NOW:   r_gain_now      <= GAIN_W'(i_cfg_data);
                CFG_GAIN_PAST:  r_gain_past     <= GAIN_W'(i_cfg_data);
                CFG_START:      r_start_pattern <= i_cfg_data[BYTE_W-1:0];
                CFG_IDLE_DRIVE: r_idle_drive    <= i_cfg_data[BYTE_W-1:0];
                default:        r_idle_drive    <= r_idle_drive;
            endcase
        end
    end

    // controller state, advanced on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_prev <= '0;
            r_pend_prev  <= '0;
            r_motor_acc  <= '0;
            r_pend_acc   <= '0;
            r_reference  <= REF_RST;
            r_started    <= 1'b0;
            r_prev_err   <= '0;
        end else if (in_xfer) begin
            r_motor_prev <= i_motor_count;
            r_pend_prev  <= i_pendulum_count;
            r_motor_acc  <= n_motor_acc;
            r_pend_acc   <= n_pend_acc;
            r_reference  <= n_reference;
            r_started    <= n_started;
            if (n_started) begin
                r_prev_err <= n_err;
            end
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= in_xfer;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_err  <= $signed(n_err);
            r_s1_ep   <= $signed(r_prev_err);
            r_s1_run  <= n_started;
            r_s1_mpos <= n_motor_acc;
            r_s1_ppos <= n_pend_acc;
        end
        if (en2 && r_v1) begin
            r_p_now   <= n_p_now;
            r_p_past  <= n_p_past;
            r_s2_run  <= r_s1_run;
            r_s2_mpos <= r_s1_mpos;
            r_s2_ppos <= r_s1_ppos;
        end
        if (en3 && r_v2) begin
            r_drive    <= n_drive;
            r_out_mpos <= r_s2_mpos;
            r_out_ppos <= r_s2_ppos;
            r_out_run  <= r_s2_run;
        end
    end

    assign o_valid             = r_v3;
    assign o_drive_code        = r_drive;
    assign o_motor_position    = $signed(r_out_mpos);
    assign o_pendulum_position = $signed(r_out_ppos);
    assign o_running           = r_out_run;

    // once running, the controller stays running until reset
    a_started_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_started) |-> r_started)
        else $error("started flag cleared without reset");

    // previous error holds on idle ticks
    a_prev_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !n_started) |=> $stable(r_prev_err))
        else $error("previous error changed while idle");

    // an empty first stage always takes a transfer
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> o_ready)
        else $error("input stalled with empty first stage");

    // a stalled result is not dropped
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !i_ready) |=> r_v3)
        else $error("stalled result lost");

endmodule

// File: tb/encoder_pd_balance_controller_top_tb.sv
// self-checking testbench for encoder_pd_balance_controller_top
// predicts encoder unwrap, start latch and pd drive per tick, checks every output transfer
// depends on epbc_pkg and the controller rtl
module encoder_pd_balance_controller_top_tb;

    import epbc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TURN_FULL   = 1 << COUNT_BITS;
    localparam int TURN_HALF   = 1 << (COUNT_BITS - 1);
    localparam int PHASE_TICKS = 190;

    typedef logic [COUNT_BITS-1:0] cnt_t;

    typedef struct {
        cnt_t              motor;
        cnt_t              pend;
        logic [BYTE_W-1:0] btn;
    } tick_t;

    typedef struct {
        logic [BYTE_W-1:0]       drive;
        logic signed [POS_W-1:0] mpos;
        logic signed [POS_W-1:0] ppos;
        logic                    run;
    } res_t;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_valid          = 1'b0;
    logic                  o_ready;
    cnt_t                  i_motor_count    = '0;
    cnt_t                  i_pendulum_count = '0;
    logic [BYTE_W-1:0]     i_button_byte    = '0;
    logic                  o_valid;
    logic                  i_ready          = 1'b0;
    logic [BYTE_W-1:0]     o_drive_code;
    logic signed [POS_W-1:0] o_motor_position;
    logic signed [POS_W-1:0] o_pendulum_position;
    logic                  o_running;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;

    encoder_pd_balance_controller_top u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_motor_count       (i_motor_count),
        .i_pendulum_count    (i_pendulum_count),
        .i_button_byte       (i_button_byte),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_drive_code        (o_drive_code),
        .o_motor_position    (o_motor_position),
        .o_pendulum_position (o_pendulum_position),
        .o_running           (o_running),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of configuration and controller state
    logic signed [GAIN_W-1:0] k_now     = GAIN_NOW_RST;
    logic signed [GAIN_W-1:0] k_past    = GAIN_PAST_RST;
    logic [BYTE_W-1:0]        start_pat = START_RST;
    logic [BYTE_W-1:0]        idle_code = IDLE_RST;
    cnt_t                     mot_last  = '0;
    cnt_t                     pen_last  = '0;
    logic [POS_W-1:0]         mot_pos   = '0;
    logic [POS_W-1:0]         pen_pos   = '0;
    logic [POS_W-1:0]         ref_pos   = REF_RST;
    logic                     run_flag  = 1'b0;
    logic [POS_W-1:0]         err_prev  = '0;

    tick_t ticks_todo[$];
    res_t  outputs_due[$];
    tick_t on_bus;
    res_t  want;
    cnt_t  mot_cnt = '0;
    cnt_t  pen_cnt = '0;

    int n_made   = 0;
    int n_taken  = 0;
    int n_seen   = 0;
    int n_err    = 0;
    int n_cycles = 0;
    int tx_wait  = 0;
    int tx_calm  = 0;
    int rx_wait  = 0;
    int rx_calm  = 0;
    int hold_left = 0;
    int n_holds  = 0;

    // count difference folded to one half turn either way
    function automatic logic [POS_W-1:0] fold_delta(cnt_t now_c, cnt_t last_c);
        int d;
        d = int'(now_c) - int'(last_c);
        if (d > TURN_HALF) begin
            d = d - TURN_FULL;
        end else if (d < -TURN_HALF) begin
            d = d + TURN_FULL;
        end
        return POS_W'(d);
    endfunction

    function automatic res_t balance_step(tick_t t);
        res_t             r;
        logic [POS_W-1:0] err;
        longint           acc;
        mot_pos  = mot_pos + fold_delta(t.motor, mot_last);
        mot_last = t.motor;
        pen_pos  = pen_pos + fold_delta(t.pend, pen_last);
        pen_last = t.pend;
        if (t.btn == start_pat) begin
            ref_pos  = pen_pos;
            run_flag = 1'b1;
        end
        if (run_flag) begin
            err = ref_pos - pen_pos;
            acc = (longint'(k_now) * longint'($signed(err))
                   + longint'(k_past) * longint'($signed(err_prev))) / 4096;
            err_prev = err;
            if (acc > DRIVE_MAX) begin
                acc = DRIVE_MAX;
            end else if (acc < DRIVE_MIN) begin
                acc = DRIVE_MIN;
            end
            r.drive = BYTE_W'(acc + 128);
        end else begin
            r.drive = idle_code;
        end
        r.mpos = mot_pos;
        r.ppos = pen_pos;
        r.run  = run_flag;
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic cnt_t next_count(cnt_t c, int scale, int bias);
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return cnt_t'($urandom);
        // steps right around half a turn, both fold directions
        if (k == 1) return c + cnt_t'(TURN_HALF - 2 + int'($urandom_range(0, 4)));
        return c + cnt_t'(bias + int'($urandom_range(0, 2 * scale)) - scale);
    endfunction

    task automatic add_tick(cnt_t m, cnt_t p, logic [BYTE_W-1:0] b);
        tick_t t;
        t.motor = m;
        t.pend  = p;
        t.btn   = b;
        mot_cnt = m;
        pen_cnt = p;
        ticks_todo.push_back(t);
        n_made++;
    endtask

    task automatic add_random(int n, int scale, int bias, int start_pct);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < n; i++) begin
            if (int'($urandom_range(0, 99)) < start_pct) begin
                b = start_pat;
            end else begin
                b = BYTE_W'($urandom);
            end
            add_tick(next_count(mot_cnt, scale, 0), next_count(pen_cnt, scale, bias), b);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GAIN_NOW:   k_now     = data;
            CFG_GAIN_PAST:  k_past    = data;
            CFG_START:      start_pat = data[BYTE_W-1:0];
            CFG_IDLE_DRIVE: idle_code = data[BYTE_W-1:0];
            default: ;
        endcase
    endtask

    // wait until every tick went in and every result came out, then let the pipe empty
    task automatic settle();
        while (n_taken != n_made || outputs_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                outputs_due.push_back(balance_step(on_bus));
                n_taken++;
            end
            if (!i_valid || o_ready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    i_valid <= 1'b0;
                end else if (ticks_todo.size() != 0) begin
                    on_bus = ticks_todo.pop_front();
                    i_motor_count    <= on_bus.motor;
                    i_pendulum_count <= on_bus.pend;
                    i_button_byte    <= on_bus.btn;
                    i_valid          <= 1'b1;
                    if (tx_calm > 0) begin
                        tx_calm--;
                        tx_wait = 0;
                    end else begin
                        tx_wait = pick_gap();
                        if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(40, 150);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // output side, with two long hold-offs to back the pipeline up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if ((n_holds == 0 && n_seen >= 500) || (n_holds == 1 && n_seen >= 1200)) begin
            n_holds++;
            hold_left = 300;
            i_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (rx_calm > 0) begin
                rx_calm--;
            end else begin
                rx_wait = pick_gap();
                if ($urandom_range(0, 49) == 0) rx_calm = $urandom_range(40, 150);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            n_seen++;
            if (outputs_due.size() == 0) begin
                $error("result transfer with nothing expected");
                n_err++;
            end else begin
                want = outputs_due.pop_front();
                if (o_drive_code !== want.drive) begin
                    $error("drive_code: expected %0d, got %0d", want.drive, o_drive_code);
                    n_err++;
                end
                if (o_motor_position !== want.mpos) begin
                    $error("motor_position: expected %0d, got %0d", want.mpos,
                           o_motor_position);
                    n_err++;
                end
                if (o_pendulum_position !== want.ppos) begin
                    $error("pendulum_position: expected %0d, got %0d", want.ppos,
                           o_pendulum_position);
                    n_err++;
                end
                if (o_running !== want.run) begin
                    $error("running: expected %0d, got %0d", want.run, o_running);
                    n_err++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [GAIN_W-1:0] gn;
        logic [GAIN_W-1:0] gp;
        logic [BYTE_W-1:0] sp;
        logic [BYTE_W-1:0] id;
        int                scale;
        int                bias;
        int                pct;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle drive extremes before anything starts
        write_reg(CFG_START, {16'($urandom), 8'hA5});
        write_reg(CFG_IDLE_DRIVE, {16'($urandom), 8'h00});
        add_tick(cnt_t'(0), cnt_t'(0), 8'h5A);
        add_tick(cnt_t'(4095), cnt_t'(4095), 8'h7F);
        settle();
        write_reg(CFG_IDLE_DRIVE, {16'($urandom), 8'hFF});
        add_tick(cnt_t'(1), cnt_t'(4094), 8'hFF);
        add_tick(cnt_t'(0), cnt_t'(0), 8'h00);
        settle();
        write_reg(CFG_START, CFG_DATA_W'(START_RST));
        write_reg(CFG_IDLE_DRIVE, CFG_DATA_W'(IDLE_RST));

        // wrap edges of the unwrap, then start, saturation both ways and re-latch
        add_tick(cnt_t'(4095), cnt_t'(4095), 8'h00);
        add_tick(cnt_t'(0), cnt_t'(0), 8'h80);
        add_tick(cnt_t'(2048), cnt_t'(2048), 8'h01);
        add_tick(cnt_t'(0), cnt_t'(0), 8'h7E);
        add_tick(cnt_t'(2049), cnt_t'(2049), 8'hFE);
        add_tick(cnt_t'(0), cnt_t'(0), 8'h40);
        add_tick(cnt_t'(4095), cnt_t'(1), 8'h20);
        add_tick(cnt_t'(4095), cnt_t'(1), START_RST);
        add_tick(cnt_t'(4095), cnt_t'(41), 8'h00);
        add_tick(cnt_t'(4095), cnt_t'(4055), 8'h00);
        add_tick(cnt_t'(4095), cnt_t'(4055), 8'h00);
        add_tick(cnt_t'(4095), cnt_t'(4056), 8'h00);
        add_tick(cnt_t'(0), cnt_t'(4056), START_RST);
        add_tick(cnt_t'(0), cnt_t'(4056), START_RST);
        add_tick(cnt_t'(0), cnt_t'(4057), 8'h00);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    gn = 24'h7FFFFF; gp = 24'h800000; sp = 8'h00; id = 8'h00;
                    scale = 30; bias = 0; pct = 8;
                end
                1: begin
                    // steady drift so the error wraps past 16 bits
                    gn = 24'h800000; gp = 24'h7FFFFF; sp = 8'hFF; id = 8'hFF;
                    scale = 600; bias = 1500; pct = 2;
                end
                2: begin
                    gn = GAIN_W'($urandom_range(0, 16384) - 8192);
                    gp = GAIN_W'($urandom_range(0, 16384) - 8192);
                    sp = BYTE_W'($urandom); id = BYTE_W'($urandom);
                    scale = 3; bias = 0; pct = 10;
                end
                3: begin
                    gn = '0; gp = '0; sp = BYTE_W'($urandom); id = BYTE_W'($urandom);
                    scale = 2000; bias = 0; pct = 8;
                end
                4: begin
                    gn = GAIN_W'($urandom); gp = GAIN_W'($urandom);
                    sp = BYTE_W'($urandom); id = BYTE_W'($urandom);
                    scale = 100; bias = -1500; pct = 3;
                end
                5: begin
                    gn = GAIN_W'($urandom_range(0, 32768) - 16384);
                    gp = GAIN_W'($urandom_range(0, 32768) - 16384);
                    sp = BYTE_W'($urandom); id = BYTE_W'($urandom);
                    scale = 10; bias = 0; pct = 12;
                end
                6: begin
                    gn = GAIN_NOW_RST; gp = GAIN_PAST_RST; sp = START_RST; id = IDLE_RST;
                    scale = 5; bias = 0; pct = 8;
                end
                default: begin
                    gn = GAIN_W'($urandom_range(0, 131072) - 65536);
                    gp = GAIN_W'($urandom_range(0, 131072) - 65536);
                    sp = BYTE_W'($urandom); id = BYTE_W'($urandom);
                    scale = 20; bias = 0; pct = 8;
                end
            endcase
            write_reg(CFG_GAIN_NOW, gn);
            write_reg(CFG_GAIN_PAST, gp);
            write_reg(CFG_START, {16'($urandom), sp});
            write_reg(CFG_IDLE_DRIVE, {16'($urandom), id});
            add_random(PHASE_TICKS, scale, bias, pct);
            settle();
        end

        if (n_err == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/epbc_pkg.sv
rtl/encoder_pd_balance_controller_top.sv
tb/encoder_pd_balance_controller_top_tb.sv
